FILE: design/otsu_histogram_threshold_top_assert.svh
// assertion macros used by the otsu threshold top level
`ifndef OTSU_HISTOGRAM_THRESHOLD_TOP_ASSERT_SVH
`define OTSU_HISTOGRAM_THRESHOLD_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/oht_pkg.sv
// shared constants and control types of the otsu threshold block
package oht_pkg;

    localparam int LIMB_W          = 32;
    localparam int PIX_W           = 8;
    localparam int THR_W           = 8;
    localparam int DEF_MAX_PIXELS  = 1048576;
    localparam int DEF_GRAY_LEVELS = 256;

    // command into the multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic two_terms;
    } t_mac_cmd;

    // status out of the multiply-accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_stat;

endpackage

FILE: design/oht_ram.sv
// generic simple dual-port ram with registered read
module oht_ram #(
    parameter int W = oht_pkg::PIX_W,
    parameter int D = oht_pkg::DEF_GRAY_LEVELS,
    localparam int ADW = $clog2(D)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [ADW-1:0] i_waddr,
    input  logic [W-1:0]   i_wdata,
    input  logic [ADW-1:0] i_raddr,
    output logic [W-1:0]   o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/oht_mac.sv
// limb-serial multiply-accumulate unit: acc = init + x1*y1 [- x2*y2]
module oht_mac #(
    parameter int OW = oht_pkg::LIMB_W,
    parameter int AW = 2 * oht_pkg::LIMB_W + 1,
    localparam int OL = (OW + oht_pkg::LIMB_W - 1) / oht_pkg::LIMB_W,
    localparam int CW = $clog2(OL + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oht_pkg::t_mac_cmd  i_cmd,
    input  logic [CW-1:0]      i_xl,
    input  logic [CW-1:0]      i_yl,
    input  logic [AW-1:0]      i_init,
    input  logic [OW-1:0]      i_x1,
    input  logic [OW-1:0]      i_y1,
    input  logic [OW-1:0]      i_x2,
    input  logic [OW-1:0]      i_y2,
    output oht_pkg::t_mac_stat o_stat,
    output logic [AW-1:0]      o_acc
);
    import oht_pkg::*;

    localparam int PADW = OL * LIMB_W;
    localparam int IW   = (OL > 1) ? $clog2(OL) : 1;
    localparam int SHW  = $clog2(2 * OL);

    logic              r_busy;
    logic              r_two;
    logic              r_t;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [CW-1:0]     r_xl;
    logic [CW-1:0]     r_yl;
    logic              r_prod_vld;
    logic              r_prod_last;
    logic              r_prod_sub;
    logic [SHW-1:0]    r_psh;
    logic [2*LIMB_W-1:0] r_prod;
    logic [AW-1:0]     r_acc;
    logic              r_done;

    logic [PADW-1:0]   x_pad;
    logic [PADW-1:0]   y_pad;
    logic [LIMB_W-1:0] x_limb;
    logic [LIMB_W-1:0] y_limb;
    logic              i_end;
    logic              j_end;
    logic              last;
    logic [AW-1:0]     addend;

    always_comb begin
        x_pad  = r_t ? PADW'(i_x2) : PADW'(i_x1);
        y_pad  = r_t ? PADW'(i_y2) : PADW'(i_y1);
        x_limb = x_pad[r_i*LIMB_W +: LIMB_W];
        y_limb = y_pad[r_j*LIMB_W +: LIMB_W];
        i_end  = (CW'(r_i) == r_xl - CW'(1));
        j_end  = (CW'(r_j) == r_yl - CW'(1));
        last   = i_end && j_end && (!r_two || r_t);
        addend = AW'(r_prod) << (LIMB_W * r_psh);
    end

    // sequencer over limb pairs, then term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= r_busy;
            r_done     <= r_prod_vld && r_prod_last;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_two <= i_cmd.two_terms;
            r_t   <= 1'b0;
            r_i   <= '0;
            r_j   <= '0;
            r_xl  <= i_xl;
            r_yl  <= i_yl;
        end else if (r_busy) begin
            if (j_end) begin
                r_j <= '0;
                if (i_end) begin
                    r_i <= '0;
                    r_t <= 1'b1;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end else begin
                r_j <= r_j + IW'(1);
            end
        end

        // one limb product per cycle
        if (r_busy) begin
            r_prod      <= (2*LIMB_W)'(x_limb) * (2*LIMB_W)'(y_limb);
            r_psh       <= SHW'(r_i) + SHW'(r_j);
            r_prod_sub  <= r_t;
            r_prod_last <= last;
        end

        if (i_cmd.start) begin
            r_acc <= i_init;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? (r_acc - addend) : (r_acc + addend);
        end
    end

    assign o_stat.busy = r_busy | r_prod_vld;
    assign o_stat.done = r_done;
    assign o_acc       = r_acc;
endmodule

FILE: design/otsu_histogram_threshold_top.sv
// otsu threshold top level: histogram build, per-frame sweep, result register
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------
//  in      | i_in_valid / o_in_ready   | i_pixel[7:0], i_last_pixel
//  out     | o_out_valid / i_out_ready | o_threshold[7:0], o_split_found
//
// pixels are taken one per cycle in S_PIX; bin update is a pipelined read-modify-write
// a last pixel starts the sweep, in which each level reads and clears its bin, then
//   makes its passes through the 32x32 mac unit
// after reset a clearing pass zeroes the bins, o_in_ready low
// a finished result waits in the output register; a new frame's sweep may end only
//   once that result has been taken
module otsu_histogram_threshold_top #(
    parameter int MAX_PIXELS  = oht_pkg::DEF_MAX_PIXELS,
    parameter int GRAY_LEVELS = oht_pkg::DEF_GRAY_LEVELS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [oht_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_last_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [oht_pkg::THR_W-1:0] o_threshold,
    output logic                      o_split_found
);
    import oht_pkg::*;
`include "otsu_histogram_threshold_top_assert.svh"

    // datapath widths
    localparam int LW   = $clog2(GRAY_LEVELS);                   // gray level
    localparam int NW   = $clog2(MAX_PIXELS + 1);                // pixel count
    localparam int SW   = $clog2(longint'(MAX_PIXELS) * longint'(GRAY_LEVELS - 1) + 1);
    localparam int PW   = SW + NW;                               // |S*n1 - N*s1|
    localparam int NUMW = 2 * PW;                                // score numerator
    localparam int DW   = 2 * NW;                                // score denominator
    localparam int AW   = NUMW + DW + 1;                         // signed accumulator
    localparam int OW   = NUMW;                                  // mac operand width
    localparam int MCW  = $clog2((OW + LIMB_W - 1) / LIMB_W + 1);

    // limb counts per operand width
    localparam int LWL  = (LW + LIMB_W - 1) / LIMB_W;
    localparam int NWL  = (NW + LIMB_W - 1) / LIMB_W;
    localparam int SWL  = (SW + LIMB_W - 1) / LIMB_W;
    localparam int PWL  = (PW + LIMB_W - 1) / LIMB_W;
    localparam int NUML = (NUMW + LIMB_W - 1) / LIMB_W;
    localparam int DWL  = (DW + LIMB_W - 1) / LIMB_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,   // zero every bin after reset
        S_PIX   = 8'b0000_0010,   // accept pixels
        S_DRAIN = 8'b0000_0100,   // last bin write lands
        S_READ  = 8'b0000_1000,   // read bin k, clear it behind
        S_LOAD  = 8'b0001_0000,   // take bin count, start s1 update
        S_MAC   = 8'b0010_0000,   // wait on a mac pass
        S_NEXT  = 8'b0100_0000,   // advance k
        S_FIN   = 8'b1000_0000    // hand result to output register
    } t_state;

    typedef enum logic [2:0] {
        OP_S1   = 3'd0,   // s1 + k*h
        OP_DIFF = 3'd1,   // S*n1 - N*s1
        OP_SQ   = 3'd2,   // diff^2
        OP_DEN  = 3'd3,   // n1*(N-n1)
        OP_CMP  = 3'd4    // num*best_den - best_num*den
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [LW-1:0] r_k, n_k;
    logic          r_out_vld, n_out_vld;

    // frame totals
    logic [NW-1:0] r_ntot;
    logic [SW-1:0] r_stot;

    // bin update pipe
    logic          r_p1_vld;
    logic [LW-1:0] r_p1_addr;
    logic          r_wr_vld;
    logic [LW-1:0] r_wr_addr;
    logic [NW-1:0] r_wr_data;

    // sweep state
    logic [NW-1:0]   r_h;
    logic [NW-1:0]   r_n1;
    logic [SW-1:0]   r_s1;
    logic [PW-1:0]   r_diff;
    logic [NUMW-1:0] r_num;
    logic [DW-1:0]   r_den;
    logic [NUMW-1:0] r_best_num;
    logic [DW-1:0]   r_best_den;
    logic [LW-1:0]   r_best_k;
    logic            r_found;

    // result register
    logic [THR_W-1:0] r_thr;
    logic             r_split;

    logic            in_acc;
    logic            take;
    logic [LW-1:0]   lvl;
    logic            k_end;
    logic            fin_go;
    logic            split_ok;
    logic            cmp_gt;
    logic [AW-1:0]   acc_mag;
    logic [NW-1:0]   inc_val;

    logic            ram_we;
    logic [LW-1:0]   ram_waddr;
    logic [NW-1:0]   ram_wdata;
    logic [LW-1:0]   ram_raddr;
    logic [NW-1:0]   ram_rdata;

    t_mac_cmd        mac_cmd;
    t_mac_stat       mac_stat;
    t_op             go_op;
    logic [MCW-1:0]  go_xl;
    logic [MCW-1:0]  go_yl;
    logic [AW-1:0]   go_init;
    logic [OW-1:0]   mx1, my1, mx2, my2;
    logic [AW-1:0]   mac_acc;

    // input side: clamp level, cap frame length
    always_comb begin
        in_acc = i_in_valid && o_in_ready;
        if (32'(i_pixel) >= GRAY_LEVELS) begin
            lvl = LW'(GRAY_LEVELS - 1);
        end else begin
            lvl = LW'(i_pixel);
        end
        take = in_acc && (r_ntot < NW'(MAX_PIXELS));
        // forward the previous write when the same bin comes twice in a row
        inc_val = ((r_wr_vld && (r_wr_addr == r_p1_addr)) ? r_wr_data : ram_rdata)
                  + NW'(1);
    end

    // histogram port sharing: pixel updates, clearing pass, sweep clear
    always_comb begin
        ram_we    = r_p1_vld || (r_state == S_CLEAR) || (r_state == S_READ);
        ram_waddr = r_p1_vld ? r_p1_addr : r_k;
        ram_wdata = r_p1_vld ? inc_val : '0;
        ram_raddr = (r_state == S_PIX) ? lvl : r_k;
    end

    oht_ram #(
        .W (NW),
        .D (GRAY_LEVELS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // accumulator interpretation
    always_comb begin
        k_end    = (r_k == LW'(GRAY_LEVELS - 1));
        fin_go   = (r_state == S_FIN) && (!r_out_vld || i_out_ready);
        split_ok = (r_n1 != '0) && (r_n1 < r_ntot);
        cmp_gt   = !mac_acc[AW-1] && (mac_acc != '0);
        acc_mag  = mac_acc[AW-1] ? (~mac_acc + AW'(1)) : mac_acc;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_op        = r_op;
        go_op       = r_op;
        mac_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (k_end) begin
                    n_state = S_PIX;
                    n_k     = '0;
                end else begin
                    n_k = r_k + LW'(1);
                end
            end
            S_PIX: begin
                if (in_acc && i_last_pixel) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_READ;
                n_k     = '0;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                mac_cmd.start = 1'b1;
                go_op         = OP_S1;
                n_state       = S_MAC;
            end
            S_MAC: begin
                if (mac_stat.done) begin
                    unique case (r_op)
                        OP_S1: begin
                            if (split_ok) begin
                                mac_cmd.start = 1'b1;
                                go_op         = OP_DIFF;
                            end else begin
                                n_state = S_NEXT;
                            end
                        end
                        OP_DIFF: begin
                            mac_cmd.start = 1'b1;
                            go_op         = OP_SQ;
                        end
                        OP_SQ: begin
                            mac_cmd.start = 1'b1;
                            go_op         = OP_DEN;
                        end
                        OP_DEN: begin
                            if (r_found) begin
                                mac_cmd.start = 1'b1;
                                go_op         = OP_CMP;
                            end else begin
                                n_state = S_NEXT;
                            end
                        end
                        OP_CMP: begin
                            n_state = S_NEXT;
                        end
                        default: begin
                            n_state = S_NEXT;
                        end
                    endcase
                end
            end
            S_NEXT: begin
                if (k_end) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + LW'(1);
                    n_state = S_READ;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_PIX;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (mac_cmd.start) begin
            n_op = go_op;
        end
        mac_cmd.two_terms = (go_op == OP_DIFF) || (go_op == OP_CMP);
        n_out_vld = fin_go || (r_out_vld && !i_out_ready);
    end

    // per-pass limb counts and start value
    always_comb begin
        go_init = '0;
        unique case (go_op)
            OP_S1: begin
                go_xl   = MCW'(LWL);
                go_yl   = MCW'(NWL);
                go_init = AW'(r_s1);
            end
            OP_DIFF: begin
                go_xl = MCW'(SWL);
                go_yl = MCW'(SWL);
            end
            OP_SQ: begin
                go_xl = MCW'(PWL);
                go_yl = MCW'(PWL);
            end
            OP_DEN: begin
                go_xl = MCW'(NWL);
                go_yl = MCW'(NWL);
            end
            OP_CMP: begin
                go_xl = MCW'(NUML);
                go_yl = MCW'(DWL);
            end
            default: begin
                go_xl = MCW'(NUML);
                go_yl = MCW'(NUML);
            end
        endcase
    end

    // operands, held stable by the registers behind them for the whole pass
    always_comb begin
        mx2 = '0;
        my2 = '0;
        unique case (r_op)
            OP_S1: begin
                mx1 = OW'(r_k);
                my1 = OW'(r_h);
            end
            OP_DIFF: begin
                mx1 = OW'(r_stot);
                my1 = OW'(r_n1);
                mx2 = OW'(r_ntot);
                my2 = OW'(r_s1);
            end
            OP_SQ: begin
                mx1 = OW'(r_diff);
                my1 = OW'(r_diff);
            end
            OP_DEN: begin
                mx1 = OW'(r_n1);
                my1 = OW'(r_ntot - r_n1);
            end
            OP_CMP: begin
                mx1 = r_num;
                my1 = OW'(r_best_den);
                mx2 = r_best_num;
                my2 = OW'(r_den);
            end
            default: begin
                mx1 = '0;
                my1 = '0;
            end
        endcase
    end

    oht_mac #(
        .OW (OW),
        .AW (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_xl    (go_xl),
        .i_yl    (go_yl),
        .i_init  (go_init),
        .i_x1    (mx1),
        .i_y1    (my1),
        .i_x2    (mx2),
        .i_y2    (my2),
        .o_stat  (mac_stat),
        .o_acc   (mac_acc)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_k       <= '0;
            r_op      <= OP_S1;
            r_out_vld <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_ntot    <= '0;
            r_stot    <= '0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_op      <= n_op;
            r_out_vld <= n_out_vld;
            r_p1_vld  <= take;
            r_wr_vld  <= r_p1_vld;
            if (take) begin
                r_ntot <= r_ntot + NW'(1);
                r_stot <= r_stot + SW'(lvl);
            end else if (fin_go) begin
                // totals start over for the next frame
                r_ntot <= '0;
                r_stot <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p1_addr <= lvl;
        end
        r_wr_addr <= r_p1_addr;
        r_wr_data <= inc_val;

        if (r_state == S_DRAIN) begin
            r_n1     <= '0;
            r_s1     <= '0;
            r_found  <= 1'b0;
            r_best_k <= '0;
        end

        if (r_state == S_LOAD) begin
            r_h  <= ram_rdata;
            r_n1 <= r_n1 + ram_rdata;
        end

        if ((r_state == S_MAC) && mac_stat.done) begin
            unique case (r_op)
                OP_S1: begin
                    r_s1 <= SW'(mac_acc);
                end
                OP_DIFF: begin
                    r_diff <= PW'(acc_mag);
                end
                OP_SQ: begin
                    r_num <= NUMW'(mac_acc);
                end
                OP_DEN: begin
                    r_den <= DW'(mac_acc);
                    // first qualifying level is taken without comparing
                    if (!r_found) begin
                        r_found    <= 1'b1;
                        r_best_k   <= r_k;
                        r_best_num <= r_num;
                        r_best_den <= DW'(mac_acc);
                    end
                end
                OP_CMP: begin
                    // strictly greater only, so ties keep the lower level
                    if (cmp_gt) begin
                        r_best_k   <= r_k;
                        r_best_num <= r_num;
                        r_best_den <= r_den;
                    end
                end
                default: begin
                end
            endcase
        end

        if (fin_go) begin
            r_thr   <= THR_W'(r_best_k);
            r_split <= r_found;
        end
    end

    assign o_in_ready    = (r_state == S_PIX);
    assign o_out_valid   = r_out_vld;
    assign o_threshold   = r_thr;
    assign o_split_found = r_split;

    `OHT_ASSERT_NOW(a_mac_start_idle, i_clk, i_rst_n, mac_cmd.start,
        !mac_stat.busy, "mac pass started while busy")
    `OHT_ASSERT_NOW(a_n1_bound, i_clk, i_rst_n, r_state == S_MAC,
        r_n1 <= r_ntot, "running count exceeds frame count")
    `OHT_ASSERT_NOW(a_bin_write_phase, i_clk, i_rst_n, r_p1_vld,
        (r_state == S_PIX || r_state == S_DRAIN), "bin update outside pixel phase")
    `OHT_ASSERT_NEXT(a_out_from_fin, i_clk, i_rst_n, !r_out_vld && !fin_go,
        !r_out_vld, "result appeared without sweep end")
endmodule

FILE: dv/testbench.sv
// self-checking testbench for the otsu threshold block: directed, backpressure, random
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import oht_pkg::*;

    localparam int MAX_PIXELS      = DEF_MAX_PIXELS;
    localparam int GRAY_LEVELS     = DEF_GRAY_LEVELS;
    // settle wait, a bit more than one full sweep
    localparam int SETTLE_CYCLES   = DEF_GRAY_LEVELS * 48;
    localparam int HOLDOFF_CYCLES  = 40000;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_PIXELS    = 130;
    localparam int PHASE_FRAMES    = 7;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int MAX_REPORTS     = 10;

    // expected threshold for one frame
    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             split_found;
    } t_otsu_result;

    // how the gray levels of a random frame are spread
    typedef enum int {
        LEVELS_UNIFORM,
        LEVELS_TWO_PEAKS,
        LEVELS_NARROW,
        LEVELS_FLAT
    } t_level_spread;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [PIX_W-1:0] i_pixel       = '0;
    logic             i_last_pixel  = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic [THR_W-1:0] o_threshold;
    logic             o_split_found;

    // predictor state: one frame's histogram and totals
    bit [20:0]        bin_count [GRAY_LEVELS];
    bit [20:0]        frame_pixels;
    bit [28:0]        frame_sum;
    t_otsu_result     pending_thresholds [$];

    int               sender_idle_pct    = 0;
    int               receiver_stall_pct = 0;
    int               holdoff_requested  = 0;
    int               holdoff_left       = 0;
    int               mismatch_count     = 0;
    int               frames_checked     = 0;
    int               pixels_sent        = 0;
    int               cycle_count        = 0;

    otsu_histogram_threshold_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_threshold   (o_threshold),
        .o_split_found (o_split_found)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // exact otsu sweep over the collected histogram, scores compared by cross-multiplying
    function automatic t_otsu_result sweep_histogram();
        t_otsu_result res;
        bit [63:0]    n1, s1, a, b, diff, den;
        bit [191:0]   num, best_num, best_den, lhs, rhs;
        bit           found;
        int           k;
        res      = '0;
        n1       = '0;
        s1       = '0;
        best_num = '0;
        best_den = '0;
        found    = 1'b0;
        for (k = 0; k < GRAY_LEVELS; k++) begin
            n1 += bin_count[k];
            s1 += 64'(k) * bin_count[k];
            // both classes must be nonempty
            if (n1 != 0 && n1 < frame_pixels) begin
                a    = frame_sum * n1;
                b    = frame_pixels * s1;
                diff = (a > b) ? a - b : b - a;
                den  = n1 * (frame_pixels - n1);
                num  = 192'(diff) * 192'(diff);
                lhs  = num * best_den;
                rhs  = best_num * 192'(den);
                // strict compare keeps the lowest level on a tie
                if (!found || lhs > rhs) begin
                    found           = 1'b1;
                    res.threshold   = k[THR_W-1:0];
                    best_num        = num;
                    best_den        = 192'(den);
                end
            end
        end
        res.split_found = found;
        return res;
    endfunction

    // fold one accepted pixel request into the frame, predict on the last one
    function automatic void accumulate_pixel(input logic [PIX_W-1:0] pix, input logic last);
        int           lvl;
        t_otsu_result predicted;
        lvl = int'(pix);
        if (lvl >= GRAY_LEVELS) begin
            lvl = GRAY_LEVELS - 1;
        end
        // pixels past the cap are dropped, but a last mark still ends the frame
        if (frame_pixels < MAX_PIXELS) begin
            bin_count[lvl]++;
            frame_pixels++;
            frame_sum += 29'(lvl);
        end
        if (last) begin
            predicted = sweep_histogram();
            pending_thresholds.insert(pending_thresholds.size(), predicted);
            foreach (bin_count[i]) begin
                bin_count[i] = '0;
            end
            frame_pixels = '0;
            frame_sum    = '0;
        end
    endfunction

    // offer one pixel request and hold it until the block takes it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel      <= pix;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        accumulate_pixel(pix, last);
        pixels_sent++;
    endtask

    task automatic send_frame(input int levels[$]);
        foreach (levels[i]) begin
            send_pixel(PIX_W'(levels[i]), i == levels.size() - 1);
        end
    endtask

    // stop offering and wait until every predicted threshold has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_thresholds.size() != 0);
    endtask

    task automatic send_random_frame();
        t_level_spread    spread;
        int               len, lo_peak, hi_peak, base, lvl, i;
        spread  = t_level_spread'($urandom_range(3));
        len     = ($urandom_range(7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        lo_peak = $urandom_range(0, 120);
        hi_peak = $urandom_range(135, 255);
        base    = $urandom_range(0, 252);
        for (i = 0; i < len; i++) begin
            case (spread)
                LEVELS_UNIFORM: begin
                    lvl = $urandom_range(255);
                end
                LEVELS_TWO_PEAKS: begin
                    lvl = ($urandom_range(1) != 0) ? lo_peak : hi_peak;
                    lvl = lvl + $urandom_range(0, 16) - 8;
                    lvl = (lvl < 0) ? 0 : ((lvl > 255) ? 255 : lvl);
                end
                LEVELS_NARROW: begin
                    lvl = base + $urandom_range(0, 3);
                end
                default: begin
                    lvl = base;
                end
            endcase
            send_pixel(PIX_W'(lvl), i == len - 1);
        end
    endtask

    // edge levels, one-level frames, ties and a mixed frame
    task automatic test_directed_frames();
        int levels[$];
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // single pixel, also the first frame after reset
        levels = '{9};
        send_frame(levels);
        // one level only: no split possible
        levels = '{5, 5, 5, 5};
        send_frame(levels);
        levels = '{255, 255};
        send_frame(levels);
        // every level from 0 to 254 scores the same, lowest must win
        levels = '{0, 255};
        send_frame(levels);
        levels = '{0, 0, 255, 255, 255};
        send_frame(levels);
        levels = '{0, 1, 1, 1};
        send_frame(levels);
        levels = '{3, 200, 17, 90, 255, 0, 128};
        send_frame(levels);
        drain_results();
    endtask

    // receiver holds off while short frames keep coming, so the input backs up
    task automatic test_output_holdoff();
        int i;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_requested  = HOLDOFF_CYCLES;
        for (i = 0; i < 6; i++) begin
            send_random_frame();
        end
        drain_results();
    endtask

    // random frames under each idling mix
    task automatic test_random_frames();
        int phase, start_pixels, start_frames;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 85;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 85;
                end
                default: begin
                    sender_idle_pct    = 23;
                    receiver_stall_pct = 23;
                end
            endcase
            start_pixels = pixels_sent;
            start_frames = frames_checked + pending_thresholds.size();
            while (pixels_sent - start_pixels < PHASE_PIXELS ||
                   frames_checked + pending_thresholds.size() - start_frames < PHASE_FRAMES) begin
                send_random_frame();
            end
        end
        drain_results();
    endtask

    // receiver side: long hold-off when asked, otherwise random stalls
    always @(posedge i_clk) begin
        if (holdoff_requested != 0) begin
            holdoff_left      = holdoff_requested;
            holdoff_requested = 0;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // compare each taken threshold with the oldest prediction
    always @(posedge i_clk) begin : check_thresholds
        t_otsu_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_thresholds.size() == 0) begin
                flag_mismatch($sformatf("threshold %0d split %0d with no frame outstanding",
                                        o_threshold, o_split_found));
            end else begin
                want = pending_thresholds.pop_front();
                frames_checked++;
                if (o_threshold !== want.threshold) begin
                    flag_mismatch($sformatf("threshold expected %0d, got %0d",
                                            want.threshold, o_threshold));
                end
                if (o_split_found !== want.split_found) begin
                    flag_mismatch($sformatf("split_found expected %0d, got %0d",
                                            want.split_found, o_split_found));
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_output_holdoff();
        test_random_frames();

        // give a stray result time to show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_thresholds.size() != 0) begin
            void'(pending_thresholds.pop_front());
            flag_mismatch("frame threshold never came out");
        end

        $display("tb: %0d frame thresholds checked over %0d pixel requests, %0d mismatches",
                 frames_checked, pixels_sent, mismatch_count);
        $display("tb: covered edge levels, ties, idle and stall mixes, %0d-cycle output hold-off",
                 HOLDOFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
